@@ rtl/hsuds_pkg.sv @@
package hsuds_pkg;

    localparam int OUT_FIFO_DEPTH = 4;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_FILTER_ENABLE = 2'd0;
    localparam logic [1:0] REG_NAL_TYPE      = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_TYPE  = 2'd2;

    localparam logic       FILTER_ENABLE_RST = 1'b1;
    localparam logic [4:0] NAL_TYPE_RST      = 5'd6;
    localparam logic [7:0] PAYLOAD_TYPE_RST  = 8'd5;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
    localparam logic [1:0] ZERO_RUN_MAX  = 2'd2;
    localparam logic [7:0] START_CODE_END = 8'h01;

    localparam logic [1:0] PHASE_BODY   = 2'd0;
    localparam logic [1:0] PHASE_HEADER = 2'd1;
    localparam logic [1:0] PHASE_HELD   = 2'd2;

    typedef struct packed {
        logic       filter_enable;
        logic [4:0] nal_type_match;
        logic [7:0] payload_type_match;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       packet_end;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } filter_out_t;

endpackage

@@ rtl/hsuds_filter.sv @@
module hsuds_filter
    import hsuds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        packet_last,
    input  cfg_t        cfg,
    output filter_out_t res
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [1:0] zero_run_reg;
    logic [1:0] zero_run_next;
    logic       dropping_reg;
    logic       dropping_next;
    logic [7:0] held_header_reg;
    logic [7:0] held_header_next;

    function automatic logic [1:0] count_zero(input logic [1:0] run, input logic [7:0] b);
        logic [1:0] r;
        if (b == 8'd0)
        begin
            r = (run < ZERO_RUN_MAX) ? run + 2'd1 : run;
        end
        else
        begin
            r = 2'd0;
        end
        return r;
    endfunction

    function automatic result_t data_result(input logic [7:0] b);
        result_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.packet_end = 1'b0;
        r.run_last   = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        logic start;
        logic match;
        phase_next       = phase_reg;
        zero_run_next    = zero_run_reg;
        dropping_next    = dropping_reg;
        held_header_next = held_header_reg;
        res              = '0;
        start            = 1'b0;
        match            = 1'b0;

        if (!cfg.filter_enable)
        begin
            if (phase_reg == PHASE_HELD)
            begin
                res.first  = data_result(held_header_reg);
                res.second = data_result(data_byte);
                res.count  = 2'd2;
            end
            else
            begin
                res.first = data_result(data_byte);
                res.count = 2'd1;
            end
            phase_next    = PHASE_BODY;
            zero_run_next = 2'd0;
            dropping_next = 1'b0;
        end
        else if (phase_reg == PHASE_HEADER)
        begin
            zero_run_next    = count_zero(zero_run_reg, data_byte);
            held_header_next = data_byte;
            phase_next       = PHASE_HELD;
            if (packet_last)
            begin
                res.first = data_result(data_byte);
                res.count = 2'd1;
            end
        end
        else if (phase_reg == PHASE_HELD)
        begin
            match = ((held_header_reg[4:0] & NAL_TYPE_MASK) == cfg.nal_type_match)
                    && (data_byte == cfg.payload_type_match);
            zero_run_next = count_zero(zero_run_reg, data_byte);
            phase_next    = PHASE_BODY;
            if (match)
            begin
                dropping_next = 1'b1;
                if (packet_last)
                begin
                    res.count = 2'd1;
                end
            end
            else
            begin
                res.first  = data_result(held_header_reg);
                res.second = data_result(data_byte);
                res.count  = 2'd2;
            end
        end
        else
        begin
            start         = (zero_run_reg == ZERO_RUN_MAX) && (data_byte == START_CODE_END);
            zero_run_next = count_zero(zero_run_reg, data_byte);
            if (start)
            begin
                dropping_next = 1'b0;
                phase_next    = PHASE_HEADER;
                zero_run_next = 2'd0;
            end
            if (!dropping_reg)
            begin
                res.first = data_result(data_byte);
                res.count = 2'd1;
            end
            else if (packet_last)
            begin
                res.count = 2'd1;
            end
        end

        if (res.count == 2'd1)
        begin
            res.first.run_last   = 1'b1;
            res.first.packet_end = packet_last;
        end
        else if (res.count == 2'd2)
        begin
            res.second.run_last   = 1'b1;
            res.second.packet_end = packet_last;
        end

        if (packet_last)
        begin
            phase_next    = PHASE_BODY;
            zero_run_next = 2'd0;
            dropping_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_BODY;
            zero_run_reg <= 2'd0;
            dropping_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            zero_run_reg <= zero_run_next;
            dropping_reg <= dropping_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_header_reg <= held_header_next;
        end
    end

endmodule

@@ rtl/h264_sei_user_data_stripper_core.sv @@
// h264 annex b sei filter: drops nal units whose type and first payload byte
// match the configured values, from the header up to the next start code
// input stream: s_tdata carries one packet byte, s_tlast marks the packet end
// output stream: m_tdata is the kept byte, m_tuser[0] says a byte is present
// (clear on a bare end marker), m_tuser[1] marks the last result of an input
// byte, m_tlast marks the final result of the packet
// apb port: filter_enable at 0x0, nal_type_match at 0x4, payload_type_match
// at 0x8; write only while the stream is idle
// latency: a result appears on m_* one cycle after its input transfer
// throughput: one byte per cycle; a byte can give zero, one or two results,
// and results wait in a small output queue, so s_tready drops only when the
// queue cannot take two more results (two-result bytes under a stalled sink)
// a stalled sink fills the queue and then holds off the source; nothing lost
// reset clears scan state, queue and registers to their defaults
module h264_sei_user_data_stripper_core
    import hsuds_pkg::*;
#(
    parameter int FIFO_DEPTH = OUT_FIFO_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte
    input  logic              s_tlast,   // packet_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic [1:0]        m_tuser,   // byte_valid, run_last
    output logic              m_tlast,   // packet_end
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(FIFO_DEPTH - 2);

    cfg_t        cfg_reg;
    filter_out_t res;
    logic        in_xfer;
    logic        out_xfer;
    logic        cfg_write;

    result_t          queue_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       push_n;
    result_t          head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // apb registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_enable      <= FILTER_ENABLE_RST;
            cfg_reg.nal_type_match     <= NAL_TYPE_RST;
            cfg_reg.payload_type_match <= PAYLOAD_TYPE_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_FILTER_ENABLE: cfg_reg.filter_enable      <= pwdata[0];
                REG_NAL_TYPE:      cfg_reg.nal_type_match     <= pwdata[4:0];
                REG_PAYLOAD_TYPE:  cfg_reg.payload_type_match <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FILTER_ENABLE: prdata = DATA_W'(cfg_reg.filter_enable);
            REG_NAL_TYPE:      prdata = DATA_W'(cfg_reg.nal_type_match);
            REG_PAYLOAD_TYPE:  prdata = DATA_W'(cfg_reg.payload_type_match);
            default:           prdata = '0;
        endcase
    end

    // filter
    assign s_tready = (count_reg <= CNT_ROOM);
    assign in_xfer  = s_tvalid && s_tready;

    hsuds_filter u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_xfer),
        .data_byte   (s_tdata),
        .packet_last (s_tlast),
        .cfg         (cfg_reg),
        .res         (res)
    );

    // output queue
    assign push_n      = in_xfer ? res.count : 2'd0;
    assign wr_ptr_plus = ptr_inc(wr_ptr_reg);
    assign out_xfer    = m_tvalid && m_tready;

    always_comb
    begin
        unique case (push_n)
            2'd1:    wr_ptr_next = wr_ptr_plus;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(out_xfer);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= res.first;
        end
        if (push_n == 2'd2)
        begin
            queue_mem[wr_ptr_plus] <= res.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (out_xfer)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    assign head     = queue_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.out_byte;
    assign m_tuser  = {head.run_last, head.byte_valid};
    assign m_tlast  = head.packet_end;

endmodule

@@ dv/h264_sei_user_data_stripper_core_tb.sv @@
`timescale 1ns / 100ps

module h264_sei_user_data_stripper_core_tb;
    import hsuds_pkg::*;

    localparam int RUN_LIMIT      = 400000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 185;
    localparam int REPORT_LIMIT   = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_SLOW,
        SINK_RARE_STALL
    } sink_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'h00;   // data_byte
    logic              s_tlast = 1'b0;    // packet_last
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;           // out_byte
    logic [1:0]        m_tuser;           // byte_valid, run_last
    logic              m_tlast;           // packet_end
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    stream_byte_t pending_in[$];
    result_t      expected_out[$];

    cfg_t         cfg_model = '{FILTER_ENABLE_RST, NAL_TYPE_RST, PAYLOAD_TYPE_RST};
    logic [1:0]   zero_count = 2'd0;
    logic [1:0]   parse_phase = PHASE_BODY;
    logic         discarding = 1'b0;
    logic [7:0]   held_nal_hdr = 8'h00;

    int           error_count = 0;
    int           cycle_count = 0;
    int           hold_request = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           mode_left = 0;
    int           slow_count = 0;
    sink_mode_t   sink_mode = SINK_ALWAYS;

    always #1 clk = ~clk;

    h264_sei_user_data_stripper_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic logic [1:0] zeros_after(input logic [7:0] b);
        if (b != 8'h00)
            return 2'd0;
        return (zero_count < ZERO_RUN_MAX) ? zero_count + 2'd1 : zero_count;
    endfunction

    function automatic result_t byte_result(input logic [7:0] b, input logic valid);
        result_t r;
        r.out_byte   = valid ? b : 8'h00;
        r.byte_valid = valid;
        r.packet_end = 1'b0;
        r.run_last   = 1'b0;
        return r;
    endfunction

    function automatic void predict_stripped_output(input logic [7:0] b, input logic last);
        result_t res[2];
        int      n;
        logic    start_code;
        logic    keep;
        logic    hit;
        n = 0;
        if (!cfg_model.filter_enable)
        begin
            if (parse_phase == PHASE_HELD)
            begin
                res[n] = byte_result(held_nal_hdr, 1'b1);
                n++;
            end
            res[n] = byte_result(b, 1'b1);
            n++;
            zero_count  = 2'd0;
            parse_phase = PHASE_BODY;
            discarding  = 1'b0;
        end
        else if (parse_phase == PHASE_HEADER)
        begin
            zero_count   = zeros_after(b);
            held_nal_hdr = b;
            parse_phase  = PHASE_HELD;
            if (last)
            begin
                res[n] = byte_result(b, 1'b1);
                n++;
            end
        end
        else if (parse_phase == PHASE_HELD)
        begin
            hit = (held_nal_hdr[4:0] == cfg_model.nal_type_match) &&
                  (b == cfg_model.payload_type_match);
            zero_count  = zeros_after(b);
            parse_phase = PHASE_BODY;
            if (hit)
            begin
                discarding = 1'b1;
                if (last)
                begin
                    res[n] = byte_result(8'h00, 1'b0);
                    n++;
                end
            end
            else
            begin
                res[0] = byte_result(held_nal_hdr, 1'b1);
                res[1] = byte_result(b, 1'b1);
                n = 2;
            end
        end
        else
        begin
            start_code = (zero_count == ZERO_RUN_MAX) && (b == START_CODE_END);
            keep       = !discarding;
            zero_count = zeros_after(b);
            if (start_code)
            begin
                discarding  = 1'b0;
                parse_phase = PHASE_HEADER;
                zero_count  = 2'd0;
            end
            if (keep)
            begin
                res[n] = byte_result(b, 1'b1);
                n++;
            end
            else if (last)
            begin
                res[n] = byte_result(8'h00, 1'b0);
                n++;
            end
        end
        if (n > 0)
        begin
            res[n-1].run_last   = 1'b1;
            res[n-1].packet_end = last;
        end
        if (last)
        begin
            zero_count  = 2'd0;
            parse_phase = PHASE_BODY;
            discarding  = 1'b0;
        end
        for (int i = 0; i < n; i++)
            expected_out.push_back(res[i]);
    endfunction

    function automatic void flag_mismatch(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (error_count < REPORT_LIMIT)
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
        error_count++;
    endfunction

    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 7))
            0, 1:    return 8'h00;
            2:       return START_CODE_END;
            3:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // source side: bursts with random gaps
    always @(posedge clk)
    begin
        stream_byte_t cur;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cur = pending_in.pop_front();
                predict_stripped_output(cur.data, cur.last);
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the offered transfer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_in.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_in[0].data;
                s_tlast  <= pending_in[0].last;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side: stall pattern plus a long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_served != hold_request)
            begin
                hold_served = hold_request;
                hold_left   = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            else
            begin
                mode_left--;
            end
            slow_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (sink_mode)
                    SINK_ALWAYS:     m_tready <= 1'b1;
                    SINK_RANDOM:     m_tready <= 1'($urandom_range(0, 1));
                    SINK_SLOW:       m_tready <= (slow_count % 3 == 0);
                    SINK_RARE_STALL: m_tready <= ($urandom_range(0, 7) != 0);
                    default:         m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (expected_out.size() == 0)
            begin
                if (error_count < REPORT_LIMIT)
                    $error("unexpected result transfer: out_byte %0h, tuser %0b, tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                error_count++;
            end
            else
            begin
                want = expected_out.pop_front();
                if (m_tdata !== want.out_byte)
                    flag_mismatch("out_byte", want.out_byte, m_tdata);
                if (m_tuser[0] !== want.byte_valid)
                    flag_mismatch("byte_valid", 8'(want.byte_valid), 8'(m_tuser[0]));
                if (m_tuser[1] !== want.run_last)
                    flag_mismatch("run_last", 8'(want.run_last), 8'(m_tuser[1]));
                if (m_tlast !== want.packet_end)
                    flag_mismatch("packet_end", 8'(want.packet_end), 8'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_in(input logic [7:0] b, input logic last);
        stream_byte_t item;
        item.data = b;
        item.last = last;
        pending_in.push_back(item);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FILTER_ENABLE: cfg_model.filter_enable      = value[0];
            REG_NAL_TYPE:      cfg_model.nal_type_match     = value[4:0];
            REG_PAYLOAD_TYPE:  cfg_model.payload_type_match = value[7:0];
            default: ;
        endcase
    endtask

    // upper bits carry junk that the block must ignore
    task automatic write_config(input logic en, input logic [4:0] nal, input logic [7:0] pay);
        write_reg(REG_FILTER_ENABLE, (32'($urandom()) << 1) | 32'(en));
        write_reg(REG_NAL_TYPE, (32'($urandom()) << 5) | 32'(nal));
        write_reg(REG_PAYLOAD_TYPE, (32'($urandom()) << 8) | 32'(pay));
    endtask

    task automatic wait_idle();
        while (pending_in.size() != 0 || expected_out.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random_packet(output int count);
        logic [7:0] pkt[$];
        int         units;
        int         u;
        logic       cut;
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 12)) pkt.push_back(body_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 2)) pkt.push_back(body_byte());
            units = $urandom_range(1, 4);
            cut   = 1'b0;
            for (u = 0; u < units && !cut; u++)
            begin
                repeat ($urandom_range(2, 4)) pkt.push_back(8'h00);
                pkt.push_back(START_CODE_END);
                if ($urandom_range(0, 15) == 0)
                begin
                    cut = 1'b1;
                end
                else
                begin
                    if ($urandom_range(0, 1) == 0)
                        pkt.push_back({3'($urandom_range(0, 7)), cfg_model.nal_type_match});
                    else
                        pkt.push_back(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 11) == 0)
                    begin
                        cut = 1'b1;
                    end
                    else
                    begin
                        if ($urandom_range(0, 1) == 0)
                            pkt.push_back(cfg_model.payload_type_match);
                        else
                            pkt.push_back(body_byte());
                        repeat ($urandom_range(0, 6)) pkt.push_back(body_byte());
                    end
                end
            end
        end
        for (int i = 0; i < pkt.size(); i++)
            push_in(pkt[i], i == pkt.size() - 1);
        count = pkt.size();
    endtask

    // {packet_last, data_byte}
    logic [8:0] directed_bytes[] = '{
        9'h011, 9'h000, 9'h000, 9'h001, 9'h006, 9'h005, 9'h0ab,
        9'h000, 9'h000, 9'h000, 9'h001, 9'h065, 9'h000,
        9'h000, 9'h001, 9'h026, 9'h105,
        9'h000, 9'h000, 9'h001, 9'h106,
        9'h1ff
    };

    initial
    begin
        int         queued;
        int         n;
        logic       en;
        logic [4:0] nal;
        logic [7:0] pay;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            push_in(directed_bytes[i][7:0], directed_bytes[i][8]);
        wait_idle();

        // header held across the filter switching off
        push_in(8'h00, 1'b0);
        push_in(8'h00, 1'b0);
        push_in(START_CODE_END, 1'b0);
        push_in(8'he6, 1'b0);
        wait_idle();
        write_reg(REG_FILTER_ENABLE, 32'hffff_fffe);
        push_in(8'h05, 1'b0);
        push_in(8'h80, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    en = 1'b1; nal = NAL_TYPE_RST; pay = PAYLOAD_TYPE_RST;
                end
                1:
                begin
                    en = 1'b1; nal = 5'd0; pay = 8'h00;
                end
                2:
                begin
                    en = 1'b1; nal = 5'd31; pay = 8'hff;
                end
                3:
                begin
                    en = 1'b0; nal = 5'($urandom()); pay = 8'($urandom());
                end
                default:
                begin
                    en = 1'b1; nal = 5'($urandom()); pay = 8'($urandom());
                end
            endcase
            write_config(en, nal, pay);
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                queue_random_packet(n);
                queued += n;
            end
            if (ph == 0)
                hold_request++;
            wait_idle();
        end

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/hsuds_pkg.sv
rtl/hsuds_filter.sv
rtl/h264_sei_user_data_stripper_core.sv
dv/h264_sei_user_data_stripper_core_tb.sv
